>>> rtl/pipeline_hazard_stall_unit_core_defines.svh
// Assertion macros shared by the hazard stall unit RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PIPELINE_HAZARD_STALL_UNIT_CORE_DEFINES_SVH
`define PIPELINE_HAZARD_STALL_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define PHSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PHSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/phsu_pkg.sv
// Shared types and constants of the pipeline hazard stall unit.
// No dependencies; every other RTL module imports this package.
`timescale 1ns / 1ps

package phsu_pkg;

  // Number of architectural registers; register numbers at or above it are dropped.
  localparam int NUM_REGS = 16;
  localparam logic [6:0] REG_LIMIT = 7'(NUM_REGS);

  // Opcodes.
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MULT = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_LW   = 3'd5;
  localparam logic [2:0] OP_SW   = 3'd6;
  localparam logic [2:0] OP_BNEZ = 3'd7;

  // Register number meaning "no register".
  localparam logic signed [4:0] NO_REG = -5'sd1;

  // Forwarding modes.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_EXMEM = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;
  localparam logic [1:0] MODE_STALL = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [4:0] dest;
    logic signed [4:0] src1;
    logic signed [4:0] src2;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '{op: OP_NOP, dest: NO_REG, src1: NO_REG, src2: NO_REG};

  typedef struct packed {
    logic              accepted;
    logic [2:0]        retire_op;
    logic signed [4:0] retire_dest;
    logic              drained;
  } res_t;

endpackage

>>> rtl/phsu_hazard.sv
// Read-after-write hazard check of the decode instruction against memory and writeback.
// Depends on phsu_pkg.
`timescale 1ns / 1ps

module phsu_hazard
  import phsu_pkg::*;
(
  input  slot_t      dec,
  input  slot_t      mem,
  input  slot_t      wb,
  input  logic [1:0] mode,
  output logic       stall
);

  logic mem_hit;
  logic wb_hit;

  // A NOP or an instruction without a destination never produces a match.
  assign mem_hit = (mem.op != OP_NOP) && (mem.dest != NO_REG) &&
                   ((mem.dest == dec.src1) || (mem.dest == dec.src2));
  assign wb_hit  = (wb.op != OP_NOP) && (wb.dest != NO_REG) &&
                   ((wb.dest == dec.src1) || (wb.dest == dec.src2));

  // The nearest matching stage alone decides.
  always_comb begin
    stall = 1'b0;
    if (dec.op != OP_NOP && (mem_hit || wb_hit)) begin
      case (mode)
        MODE_EXMEM: stall = !mem_hit;
        MODE_FULL:  stall = 1'b0;
        MODE_NONE:  stall = 1'b1;
        MODE_STALL: stall = 1'b1;
        default:    stall = 1'b1;
      endcase
    end
  end

endmodule

>>> rtl/phsu_slots.sv
// Five pipeline slot registers and their one-step advance, with the hazard check.
// Depends on phsu_pkg, phsu_hazard and the shared assertion macros.
`timescale 1ns / 1ps
`include "pipeline_hazard_stall_unit_core_defines.svh"

module phsu_slots
  import phsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  slot_t      in_slot,
  input  logic [1:0] mode,
  output res_t       res
);

  slot_t fetch;
  slot_t dec;
  slot_t exe;
  slot_t mem;
  slot_t wb;
  slot_t fetch_next;
  slot_t dec_next;
  slot_t exe_next;
  logic  stall;

  // After the shift, execute has gone to memory and memory to writeback.
  phsu_hazard u_hazard (
    .dec   (dec),
    .mem   (exe),
    .wb    (mem),
    .mode  (mode),
    .stall (stall)
  );

  always_comb begin
    if (stall) begin
      fetch_next = fetch;
      dec_next   = dec;
      exe_next   = SLOT_EMPTY;
    end else begin
      fetch_next = in_slot;
      dec_next   = fetch;
      exe_next   = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch <= SLOT_EMPTY;
      dec   <= SLOT_EMPTY;
      exe   <= SLOT_EMPTY;
      mem   <= SLOT_EMPTY;
      wb    <= SLOT_EMPTY;
    end else if (step) begin
      fetch <= fetch_next;
      dec   <= dec_next;
      exe   <= exe_next;
      mem   <= exe;
      wb    <= mem;
    end
  end

  assign res.accepted    = !stall;
  assign res.retire_op   = mem.op;
  assign res.retire_dest = mem.dest;
  assign res.drained     = (fetch_next.op == OP_NOP) && (dec_next.op == OP_NOP) &&
                           (exe_next.op == OP_NOP) && (exe.op == OP_NOP) &&
                           (mem.op == OP_NOP);

  `PHSU_ASSERT_NOW(a_nop_decode_no_stall, step && dec.op == OP_NOP, res.accepted, "NOP in decode stalled")
  `PHSU_ASSERT_NOW(a_full_fwd_no_stall, step && mode == MODE_FULL, res.accepted, "stall under full forwarding")
  `PHSU_ASSERT_NEXT(a_bubble_on_stall, step && stall, exe.op == OP_NOP && $stable(dec), "stall did not insert a bubble")
  `PHSU_ASSERT_NEXT(a_idle_holds, !step, $stable(wb) && $stable(fetch), "slots moved without a step")

endmodule

>>> rtl/pipeline_hazard_stall_unit_core.sv
// Top level of the pipeline hazard stall unit: stream ports, input and result registers.
// Depends on phsu_pkg, phsu_slots and the shared assertion macros.
`timescale 1ns / 1ps
`include "pipeline_hazard_stall_unit_core_defines.svh"

// Each input transaction advances a modeled five-stage in-order pipeline (fetch, decode,
// execute, memory, writeback) by one step. The transaction offers the next instruction;
// the block moves execute to memory and memory to writeback, then checks the decode
// instruction for a read-after-write match against the new memory and writeback stages
// under the forwarding mode written through cfg_wr_en/cfg_wr_data (reset value 0). On a
// stall a bubble enters execute, decode and fetch hold, and the result reports
// accepted = 0, meaning the same instruction must be sent again in a later transaction.
// Register numbers that are negative or at or above the register count are stored as
// "no register". Every input transaction yields exactly one result transaction: the input
// is held in the input register, then its result in the result register. The unit accepts
// one transaction per clock as long as the result side keeps up; the rate is set by the
// single combinational step between the input register and the pipeline slot registers.
// Write the mode only while no transaction is in flight.
module pipeline_hazard_stall_unit_core
  import phsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration: forwarding mode.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // Offered instructions.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // next_op[2:0], next_dest[7:3], next_src1[12:8],
                                     // next_src2[17:13], zero[23:18]
  // Step results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // accepted[0], retire_op[3:1], retire_dest[8:4],
                                     // drained[9], zero[15:10]
);

  logic [1:0] mode;
  slot_t      in_slot;
  logic       in_vld;
  res_t       res_next;
  res_t       res_q;
  logic       out_vld;
  logic       step;
  slot_t      raw_slot;

  // Any register number outside the register file reads as "no register".
  function automatic logic signed [4:0] reg_clean(input logic [4:0] raw);
    logic signed [4:0] v;
    if (raw[4] || ({3'b000, raw[3:0]} >= REG_LIMIT)) begin
      v = NO_REG;
    end else begin
      v = raw;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  // The held item is processed whenever the result register is free or being emptied.
  assign step          = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || step;

  assign raw_slot.op   = s_axis_tdata[2:0];
  assign raw_slot.dest = reg_clean(s_axis_tdata[7:3]);
  assign raw_slot.src1 = reg_clean(s_axis_tdata[12:8]);
  assign raw_slot.src2 = reg_clean(s_axis_tdata[17:13]);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_slot <= raw_slot;
    end
  end

  phsu_slots u_slots (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_slot (in_slot),
    .mode    (mode),
    .res     (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (step) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'b000000, res_q.drained, res_q.retire_dest,
                          res_q.retire_op, res_q.accepted};

  `PHSU_ASSERT_NOW(a_no_overwrite, out_vld && !m_axis_tready, !step, "result overwritten while stalled")
  `PHSU_ASSERT_NEXT(a_step_gives_result, step, out_vld, "step without a result")
  `PHSU_ASSERT_NOW(a_no_step_when_empty, !in_vld, !step, "step without a held item")

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for pipeline_hazard_stall_unit_core: directed and random instruction
// streams, with a behavioral pipeline predictor that checks every step result.
// Depends on phsu_pkg and the RTL of the hazard stall unit.
`timescale 1ns / 1ps

module tb_top;
  import phsu_pkg::*;

  // Stage positions inside the predictor's copy of the pipeline.
  localparam int ST_FETCH   = 0;
  localparam int ST_DECODE  = 1;
  localparam int ST_EXEC    = 2;
  localparam int ST_MEM     = 3;
  localparam int ST_WB      = 4;
  localparam int NUM_STAGES = 5;

  // Watchdog bound on the length of a run, in clock cycles.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  // Two register stages between input and result, plus some margin.
  localparam int SETTLE_TICKS = 6;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [1:0]  cfg_wr_data   = MODE_NONE;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // next_op[2:0], next_dest[7:3], next_src1[12:8],
                                    // next_src2[17:13], zero[23:18]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // accepted[0], retire_op[3:1], retire_dest[8:4],
                                    // drained[9], zero[15:10]

  // Predictor state: the five pipeline slots and the forwarding mode.
  slot_t      pipe_slots [NUM_STAGES];
  logic [1:0] fwd_mode;

  // Predicted step results, oldest first.
  res_t step_results_q [$];

  int fail_count    = 0;
  int cycle_count   = 0;
  // Idle percentages for the sender and the receiver, and a long receiver hold-off.
  int tx_idle_pct   = 20;
  int rx_idle_pct   = 20;
  int holdoff_ticks = 0;

  pipeline_hazard_stall_unit_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline predictor
  // ---------------------------------------------------------------------------------------

  // Register numbers outside 0..NUM_REGS-1 are stored as "no register".
  function automatic logic signed [4:0] legal_reg(logic signed [4:0] r);
    if (r < 0 || r >= NUM_REGS) return NO_REG;
    return r;
  endfunction

  // Read-after-write check of the decode instruction against memory and writeback. The
  // nearest stage with a match decides; NOPs neither cause nor take part in a match.
  function automatic bit raw_hazard_stall();
    slot_t d;
    slot_t p;
    d = pipe_slots[ST_DECODE];
    if (d.op == OP_NOP) return 1'b0;
    for (int i = ST_MEM; i <= ST_WB; i++) begin
      p = pipe_slots[i];
      if (p.op == OP_NOP || p.dest == NO_REG) continue;
      if (p.dest == d.src1 || p.dest == d.src2) begin
        case (fwd_mode)
          MODE_EXMEM: return (i == ST_WB);
          MODE_FULL:  return 1'b0;
          default:    return 1'b1;
        endcase
      end
    end
    return 1'b0;
  endfunction

  // Advances the predicted pipeline by one step and returns the step result.
  function automatic res_t advance_pipeline(slot_t offered);
    res_t  r;
    slot_t n;
    pipe_slots[ST_WB]  = pipe_slots[ST_MEM];
    pipe_slots[ST_MEM] = pipe_slots[ST_EXEC];
    if (raw_hazard_stall()) begin
      // A bubble enters execute while decode and fetch hold.
      pipe_slots[ST_EXEC] = SLOT_EMPTY;
      r.accepted = 1'b0;
    end else begin
      n.op   = offered.op;
      n.dest = legal_reg(offered.dest);
      n.src1 = legal_reg(offered.src1);
      n.src2 = legal_reg(offered.src2);
      pipe_slots[ST_EXEC]   = pipe_slots[ST_DECODE];
      pipe_slots[ST_DECODE] = pipe_slots[ST_FETCH];
      pipe_slots[ST_FETCH]  = n;
      r.accepted = 1'b1;
    end
    r.retire_op   = pipe_slots[ST_WB].op;
    r.retire_dest = pipe_slots[ST_WB].dest;
    r.drained     = 1'b1;
    for (int i = 0; i < NUM_STAGES; i++)
      if (pipe_slots[i].op != OP_NOP) r.drained = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------------------

  function automatic slot_t make_instr(logic [2:0] op, logic signed [4:0] dest,
                                       logic signed [4:0] src1, logic signed [4:0] src2);
    slot_t s;
    s.op   = op;
    s.dest = dest;
    s.src1 = src1;
    s.src2 = src2;
    return s;
  endfunction

  // Mostly a few low registers so that read-after-write matches are frequent, with some
  // "none", the full legal range and raw 5-bit patterns (negative ones are dropped).
  function automatic logic signed [4:0] pick_reg();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 5'($urandom_range(3));
    if (r < 75) return NO_REG;
    if (r < 92) return 5'($urandom_range(15));
    return 5'($urandom);
  endfunction

  function automatic slot_t random_instr();
    return make_instr(3'($urandom_range(7)), pick_reg(), pick_reg(), pick_reg());
  endfunction

  // Offers one instruction as an input transaction and predicts its step result. The
  // sender may idle first. The predicted acceptance is returned so that
  // a refused instruction can be offered again.
  task automatic send_instr(input slot_t instr, output bit taken);
    res_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, instr.src2, instr.src1, instr.dest, instr.op};
    do @(posedge clk); while (!s_axis_tready);
    predicted = advance_pipeline(instr);
    step_results_q = {step_results_q, predicted};
    taken = predicted.accepted;
  endtask

  // Keeps offering the same instruction until the pipeline takes it, as a real fetch
  // unit would after a stall.
  task automatic issue_instr(input logic [2:0] op, input logic signed [4:0] dest,
                             input logic signed [4:0] src1, input logic signed [4:0] src2);
    bit taken;
    do send_instr(make_instr(op, dest, src1, src2), taken); while (!taken);
  endtask

  // Waits until every predicted result has come back and the block has settled.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // The mode register is only written while no transaction is in flight.
  task automatic write_mode(input logic [1:0] mode);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    fwd_mode = mode;
  endtask

  // Random stream: a refused instruction is usually offered again, but now and then a
  // fresh one replaces it to exercise the block outside the normal protocol.
  task automatic random_stream(input int count);
    slot_t instr;
    bit    taken;
    taken = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (taken || $urandom_range(9) == 0) instr = random_instr();
      send_instr(instr, taken);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------------------

  // Right after reset the pipeline is empty, so NOPs retire and everything reads drained.
  // The out-of-range destination on the NOP must also be dropped.
  task automatic test_reset_state();
    issue_instr(OP_NOP, NO_REG, NO_REG, NO_REG);
    issue_instr(OP_NOP, -5'sd16, 5'sd15, -5'sd16);
  endtask

  // Extremes of every field and the remaining opcodes. A NOP that names register 2 as its
  // destination must not stall a later reader of register 2. SW keeps its operands
  // exactly as given, while the negative second source of BNEZ is dropped.
  task automatic test_field_extremes();
    issue_instr(OP_NOP,  5'sd2,   5'sd15,  -5'sd16);
    issue_instr(OP_DIV,  5'sd15,  5'sd2,   5'sd2);
    issue_instr(OP_SW,   NO_REG,  5'sd15,  5'sd0);
    issue_instr(OP_MULT, 5'sd0,   5'sd15,  5'sd15);
    issue_instr(OP_BNEZ, 5'sd0,   5'sd0,   -5'sd6);
  endtask

  // In every mode: a producer, a second producer of the same register, a reader that sees
  // matches in memory and writeback at once (memory is nearest, so mode 1 does not stall)
  // and a reader that only sees writeback.
  task automatic test_forwarding_modes();
    logic [1:0] modes [4] = '{MODE_NONE, MODE_EXMEM, MODE_FULL, MODE_STALL};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      issue_instr(OP_ADD,  5'sd1,  5'sd3,  NO_REG);
      issue_instr(OP_LW,   5'sd1,  5'sd4,  NO_REG);
      issue_instr(OP_SUB,  5'sd5,  5'sd1,  5'sd7);
      issue_instr(OP_BNEZ, NO_REG, 5'sd6,  5'sd1);
    end
  endtask

  // Random traffic in each mode, reset value last.
  task automatic test_random_mix();
    logic [1:0] modes [4] = '{MODE_EXMEM, MODE_FULL, MODE_STALL, MODE_NONE};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      random_stream(250);
    end
  endtask

  // A long stretch with neither side idling.
  task automatic test_full_rate();
    write_mode(2'($urandom_range(3)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_stream(200);
    tx_idle_pct = 20;
    rx_idle_pct = 20;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // result side fills up and the block has to stop taking input transactions.
  task automatic test_back_pressure();
    write_mode(MODE_EXMEM);
    tx_idle_pct   = 0;
    holdoff_ticks = 300;
    random_stream(150);
    tx_idle_pct   = 20;
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------------------

  // Compares one result transaction, field by field, against the oldest prediction.
  task automatic check_result(input logic [15:0] word);
    res_t got;
    res_t want;
    got.accepted    = word[0];
    got.retire_op   = word[3:1];
    got.retire_dest = word[8:4];
    got.drained     = word[9];
    if (step_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("[%0t] result transaction with nothing predicted: %h", $realtime, word);
    end else begin
      want = step_results_q.pop_front();
      if (got.accepted !== want.accepted || got.retire_op !== want.retire_op ||
          got.retire_dest !== want.retire_dest || got.drained !== want.drained) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display({"[%0t] mismatch: expected acc=%b op=%0d dest=%0d drained=%b,",
                    " got acc=%b op=%0d dest=%0d drained=%b"},
                   $realtime, want.accepted, want.retire_op, want.retire_dest, want.drained,
                   got.accepted, got.retire_op, got.retire_dest, got.drained);
      end
    end
  endtask

  // Samples handshakes with the values from before the edge, then decides whether the
  // receiver is ready for the next cycle. A pending hold-off overrides the random stalls.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (holdoff_ticks > 0) begin
      m_axis_tready <= 1'b0;
      holdoff_ticks--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog for a block that stops responding.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    int drain_ticks;
    foreach (pipe_slots[i]) pipe_slots[i] = SLOT_EMPTY;
    fwd_mode = MODE_NONE;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_forwarding_modes();
    test_random_mix();
    test_full_rate();
    test_back_pressure();

    // Let the last results come back, within a bound, then allow the block to settle.
    s_axis_tvalid <= 1'b0;
    drain_ticks = 0;
    while (step_results_q.size() != 0 && drain_ticks < 5000) begin
      @(posedge clk);
      drain_ticks++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);
    if (step_results_q.size() != 0) begin
      fail_count += step_results_q.size();
      $display("%0d predicted results never arrived", step_results_q.size());
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> pipeline_hazard_stall_unit_core.f
+incdir+rtl
rtl/phsu_pkg.sv
rtl/phsu_hazard.sv
rtl/phsu_slots.sv
rtl/pipeline_hazard_stall_unit_core.sv
bench/tb_top.sv
